// ----- hw/rtl/ltc_pkg.sv -----
// ltc_pkg: shared types and constants for the LRU tile cache.
// Used by ltc_front, ltc_back and lru_tile_cache; depends on nothing.
`default_nettype none

package ltc_pkg;

    localparam int KEY_BITS       = 27;
    localparam int WIDX_BITS      = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;
    localparam int CMD_DEPTH      = 4;
    localparam int OUT_DEPTH      = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_WORDS = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] CAPACITY_RESET   = 5'd16;
    localparam logic [CFG_DATA_BITS-1:0] TILE_WORDS_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_GET_HIT,
        CMD_GET_MISS
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic      hit;
        logic      evicted;
        logic      ack;
    } t_cmd_flags;

    localparam int CMD_FLAG_BITS = $bits(t_cmd_flags);

    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } t_back_state;

endpackage

`default_nettype wire

// ----- hw/rtl/ltc_fifo.sv -----
// ltc_fifo: small register queue with occupancy count.
// Used for the command queue and the result queue; no package dependency.
`default_nettype none

module ltc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_data,
    input  wire logic                           i_pop,
    output logic      [WIDTH-1:0]               o_data,
    output logic                                o_full,
    output logic                                o_empty,
    output logic      [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      r_mem [DEPTH];
    logic [PTR_BITS-1:0]   r_head;
    logic [PTR_BITS-1:0]   r_tail;
    logic [COUNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0]   n_head;
    logic [PTR_BITS-1:0]   n_tail;
    logic [COUNT_BITS-1:0] n_count;
    logic                  do_push;
    logic                  do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail = (r_tail == PTR_BITS'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (do_pop) begin
            n_head = (r_head == PTR_BITS'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_data  = r_mem[r_head];
    assign o_full  = (r_count == COUNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- hw/rtl/ltc_front.sv -----
// ltc_front: key lookup, LRU ranking and slot allocation for each item.
// Emits one command per item that does work; depends on ltc_pkg.
`default_nettype none

module ltc_front #(
    parameter int ENTRIES    = 16,
    parameter int SLOT_BITS  = 4,
    parameter int CAP_BITS   = 5,
    parameter int TW_BITS    = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_operation,
    input  wire logic [ltc_pkg::KEY_BITS-1:0]  i_key,
    input  wire logic [ltc_pkg::WIDX_BITS-1:0] i_word_index,
    input  wire logic [CAP_BITS-1:0]           i_eff_cap,
    input  wire logic [TW_BITS-1:0]            i_eff_words,
    output logic                               o_cmd_push,
    output ltc_pkg::t_cmd_flags                o_cmd_flags,
    output logic      [SLOT_BITS-1:0]          o_cmd_slot
);

    logic [ltc_pkg::KEY_BITS-1:0] r_key  [ENTRIES];
    logic [SLOT_BITS-1:0]         r_rank [ENTRIES];
    logic [CAP_BITS-1:0]          r_count;
    logic [SLOT_BITS-1:0]         r_put_slot;
    logic                         r_put_hit;
    logic                         r_put_evicted;

    logic [ENTRIES-1:0]   valid;
    logic [ENTRIES-1:0]   match;
    logic                 found;
    logic [SLOT_BITS-1:0] found_slot;
    logic [SLOT_BITS-1:0] found_rank;
    logic [SLOT_BITS-1:0] oldest_rank;
    logic [SLOT_BITS-1:0] victim_slot;
    logic [CAP_BITS-1:0]  count_less;

    logic                 is_put;
    logic                 in_tile;
    logic                 word_last;
    logic                 head;
    logic                 cache_full;
    logic [SLOT_BITS-1:0] new_slot;
    logic                 new_hit;
    logic                 new_evicted;
    logic                 insert;
    logic                 key_we;
    logic                 touch;
    logic                 touch_fresh;
    logic [SLOT_BITS-1:0] touch_slot;

    assign count_less  = r_count - CAP_BITS'(1);
    assign oldest_rank = count_less[SLOT_BITS-1:0];

    always_comb begin
        found_slot  = '0;
        found_rank  = '0;
        victim_slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            valid[i] = CAP_BITS'(i) < r_count;
            match[i] = valid[i] && (r_key[i] == i_key);
            if (match[i]) begin
                found_slot = found_slot | SLOT_BITS'(i);
                found_rank = found_rank | r_rank[i];
            end
            if (valid[i] && (r_rank[i] == oldest_rank)) begin
                victim_slot = victim_slot | SLOT_BITS'(i);
            end
        end
        found = |match;
    end

    assign is_put     = (i_operation == ltc_pkg::OP_PUT);
    assign in_tile    = 32'(i_word_index) < 32'(i_eff_words);
    assign word_last  = (32'(i_word_index) + 32'd1) == 32'(i_eff_words);
    assign head       = is_put && in_tile && (i_word_index == '0);
    assign cache_full = r_count >= i_eff_cap;

    always_comb begin
        new_slot    = r_put_slot;
        new_hit     = r_put_hit;
        new_evicted = r_put_evicted;
        insert      = 1'b0;
        key_we      = 1'b0;
        touch       = 1'b0;
        touch_fresh = 1'b0;
        touch_slot  = found_slot;
        priority if (!is_put) begin
            touch = found;
        end else if (head && found) begin
            new_slot    = found_slot;
            new_hit     = 1'b1;
            new_evicted = 1'b0;
            touch       = 1'b1;
        end else if (head && cache_full) begin
            new_slot    = victim_slot;
            new_hit     = 1'b0;
            new_evicted = 1'b1;
            key_we      = 1'b1;
            touch       = 1'b1;
            touch_fresh = 1'b1;
            touch_slot  = victim_slot;
        end else if (head) begin
            new_slot    = r_count[SLOT_BITS-1:0];
            new_hit     = 1'b0;
            new_evicted = 1'b0;
            insert      = 1'b1;
            key_we      = 1'b1;
            touch       = 1'b1;
            touch_fresh = 1'b1;
            touch_slot  = r_count[SLOT_BITS-1:0];
        end else begin
            touch = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_put_slot    <= '0;
            r_put_hit     <= 1'b0;
            r_put_evicted <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_accept) begin
            if (insert) begin
                r_count <= r_count + CAP_BITS'(1);
            end
            if (head) begin
                r_put_slot    <= new_slot;
                r_put_hit     <= new_hit;
                r_put_evicted <= new_evicted;
            end
            if (touch) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (SLOT_BITS'(i) == touch_slot) begin
                        r_rank[i] <= '0;
                    end else if (valid[i] && (touch_fresh || (r_rank[i] < found_rank))) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && key_we) begin
            r_key[touch_slot] <= i_key;
        end
    end

    always_comb begin
        o_cmd_push          = i_accept && (!is_put || in_tile);
        o_cmd_flags.ack     = is_put && word_last;
        o_cmd_flags.hit     = is_put ? new_hit : found;
        o_cmd_flags.evicted = is_put && new_evicted;
        if (is_put) begin
            o_cmd_flags.kind = ltc_pkg::CMD_PUT;
            o_cmd_slot       = new_slot;
        end else if (found) begin
            o_cmd_flags.kind = ltc_pkg::CMD_GET_HIT;
            o_cmd_slot       = found_slot;
        end else begin
            o_cmd_flags.kind = ltc_pkg::CMD_GET_MISS;
            o_cmd_slot       = '0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ltc_back.sv -----
// ltc_back: executes commands against the tile memory and queues results.
// Depends on ltc_pkg and ltc_fifo.
`default_nettype none

module ltc_back #(
    parameter int ENTRIES    = 16,
    parameter int TILE_WORDS = 16,
    parameter int WORD_BITS  = 32,
    parameter int SLOT_BITS  = 4,
    parameter int TW_BITS    = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire ltc_pkg::t_cmd_flags           i_cmd_flags,
    input  wire logic [SLOT_BITS-1:0]          i_cmd_slot,
    input  wire logic [ltc_pkg::WIDX_BITS-1:0] i_cmd_widx,
    input  wire logic [WORD_BITS-1:0]          i_cmd_data,
    output logic                               o_cmd_pop,
    input  wire logic [TW_BITS-1:0]            i_eff_words,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic                               o_hit,
    output logic      [SLOT_BITS-1:0]          o_slot,
    output logic      [WORD_BITS-1:0]          o_read_word,
    output logic                               o_last,
    output logic                               o_evicted
);

    localparam int MEM_WORDS = ENTRIES * TILE_WORDS;
    localparam int AW        = $clog2(MEM_WORDS);
    localparam int CNT_BITS  = (TILE_WORDS > 1) ? $clog2(TILE_WORDS) : 1;
    localparam int RES_BITS  = SLOT_BITS + WORD_BITS + 3;
    localparam int OCW       = $clog2(ltc_pkg::OUT_DEPTH + 1);

    logic [WORD_BITS-1:0] r_mem [MEM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    ltc_pkg::t_back_state r_state;
    ltc_pkg::t_back_state n_state;
    logic [SLOT_BITS-1:0] r_slot;
    logic [CNT_BITS-1:0]  r_cnt;

    logic                 r_p_valid;
    logic                 r_p_hit;
    logic [SLOT_BITS-1:0] r_p_slot;
    logic                 r_p_last;
    logic                 r_p_evicted;
    logic                 r_p_rd;

    logic                 room;
    logic                 cnt_last;
    logic                 load;
    logic                 mem_we;
    logic                 mem_re;
    logic                 issue;
    logic                 iss_hit;
    logic [SLOT_BITS-1:0] iss_slot;
    logic                 iss_last;
    logic                 iss_evicted;
    logic                 iss_rd;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;

    logic [RES_BITS-1:0]  res_in;
    logic [RES_BITS-1:0]  res_out;
    logic [OCW-1:0]       out_count;
    logic                 out_full;
    logic [WORD_BITS-1:0] res_word;

    assign room     = (32'(out_count) + 32'(r_p_valid)) < ltc_pkg::OUT_DEPTH;
    assign cnt_last = (32'(r_cnt) + 32'd1) == 32'(i_eff_words);
    assign wr_addr  = AW'(i_cmd_slot) * AW'(TILE_WORDS) + AW'(i_cmd_widx);
    assign rd_addr  = AW'(r_slot) * AW'(TILE_WORDS) + AW'(r_cnt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltc_pkg::BK_IDLE: begin
                if (i_cmd_valid && (i_cmd_flags.kind == ltc_pkg::CMD_GET_HIT)) begin
                    n_state = ltc_pkg::BK_STREAM;
                end
            end
            ltc_pkg::BK_STREAM: begin
                if (room && cnt_last) begin
                    n_state = ltc_pkg::BK_IDLE;
                end
            end
            default: n_state = ltc_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        load        = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        issue       = 1'b0;
        iss_hit     = i_cmd_flags.hit;
        iss_slot    = i_cmd_slot;
        iss_last    = 1'b1;
        iss_evicted = i_cmd_flags.evicted;
        iss_rd      = 1'b0;
        unique case (r_state)
            ltc_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd_flags.kind)
                        ltc_pkg::CMD_GET_HIT: begin
                            o_cmd_pop = 1'b1;
                            load      = 1'b1;
                        end
                        ltc_pkg::CMD_PUT: begin
                            if (!i_cmd_flags.ack || room) begin
                                o_cmd_pop = 1'b1;
                                mem_we    = 1'b1;
                                issue     = i_cmd_flags.ack;
                            end
                        end
                        ltc_pkg::CMD_GET_MISS: begin
                            if (room) begin
                                o_cmd_pop = 1'b1;
                                issue     = 1'b1;
                            end
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            ltc_pkg::BK_STREAM: begin
                if (room) begin
                    mem_re      = 1'b1;
                    issue       = 1'b1;
                    iss_hit     = 1'b1;
                    iss_slot    = r_slot;
                    iss_last    = cnt_last;
                    iss_evicted = 1'b0;
                    iss_rd      = 1'b1;
                end
            end
            default: o_cmd_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ltc_pkg::BK_IDLE;
            r_p_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot <= i_cmd_slot;
            r_cnt  <= '0;
        end else if (mem_re) begin
            r_cnt  <= r_cnt + 1'b1;
        end
        if (issue) begin
            r_p_hit     <= iss_hit;
            r_p_slot    <= iss_slot;
            r_p_last    <= iss_last;
            r_p_evicted <= iss_evicted;
            r_p_rd      <= iss_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_cmd_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign res_word = r_p_rd ? r_rd_data : '0;
    assign res_in   = {r_p_hit, r_p_slot, res_word, r_p_last, r_p_evicted};

    ltc_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (ltc_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p_valid),
        .i_data  (res_in),
        .i_pop   (i_pop),
        .o_data  (res_out),
        .o_full  (out_full),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign {o_hit, o_slot, o_read_word, o_last, o_evicted} =
        out_full ? res_out : res_out;

endmodule

`default_nettype wire

// ----- hw/rtl/lru_tile_cache.sv -----
// lru_tile_cache: fully associative LRU tile cache, top level.
// Path: a put acknowledge (on its last word) and a miss result pass the command
// queue, the result register and the result queue; a get hit adds the tile read.
// Throughput: one put word per cycle while the command queue is not full; a get
// hit streams one word per cycle while results have room and holds later commands.
// Reset (synchronous): registers to 16/16, cache and queues empty, no sweep.
`default_nettype none

module lru_tile_cache #(
    parameter int ENTRIES    = 16,
    parameter int TILE_WORDS = 16,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                i_operation,
    input  wire logic [7:0]                          i_batch_index,
    input  wire logic [6:0]                          i_head_index,
    input  wire logic [11:0]                         i_tile_index,
    input  wire logic [ltc_pkg::WIDX_BITS-1:0]       i_word_index,
    input  wire logic [WORD_BITS-1:0]                i_data_word,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     o_hit,
    output logic      [$clog2(ENTRIES)-1:0]          o_slot,
    output logic      [WORD_BITS-1:0]                o_read_word,
    output logic                                     o_last,
    output logic                                     o_evicted,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ltc_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [ltc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int SLOT_BITS = $clog2(ENTRIES);
    localparam int CAP_BITS  = $clog2(ENTRIES + 1);
    localparam int TW_BITS   = $clog2(TILE_WORDS + 1);
    localparam int CMD_BITS  = ltc_pkg::CMD_FLAG_BITS + SLOT_BITS + ltc_pkg::WIDX_BITS
                               + WORD_BITS;

    logic [ltc_pkg::CFG_DATA_BITS-1:0] r_capacity;
    logic [ltc_pkg::CFG_DATA_BITS-1:0] r_tile_words;
    logic [CAP_BITS-1:0]               eff_cap;
    logic [TW_BITS-1:0]                eff_words;

    logic                         accept;
    logic [ltc_pkg::KEY_BITS-1:0] key;
    logic                         cmd_push;
    ltc_pkg::t_cmd_flags          cmd_flags;
    logic [SLOT_BITS-1:0]         cmd_slot;
    logic [CMD_BITS-1:0]          cmd_in;
    logic [CMD_BITS-1:0]          cmd_out;
    logic                         cmd_empty;
    logic                         cmd_pop;
    ltc_pkg::t_cmd_flags          q_flags;
    logic [SLOT_BITS-1:0]         q_slot;
    logic [ltc_pkg::WIDX_BITS-1:0] q_widx;
    logic [WORD_BITS-1:0]         q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= ltc_pkg::CAPACITY_RESET;
            r_tile_words <= ltc_pkg::TILE_WORDS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == ltc_pkg::CFG_CAPACITY) begin
                r_capacity <= i_cfg_data;
            end else if (i_cfg_index == ltc_pkg::CFG_TILE_WORDS) begin
                r_tile_words <= i_cfg_data;
            end
        end
    end

    always_comb begin
        priority if (r_capacity == '0) begin
            eff_cap = CAP_BITS'(1);
        end else if (32'(r_capacity) > ENTRIES) begin
            eff_cap = CAP_BITS'(ENTRIES);
        end else begin
            eff_cap = CAP_BITS'(r_capacity);
        end
        priority if (r_tile_words == '0) begin
            eff_words = TW_BITS'(1);
        end else if (32'(r_tile_words) > TILE_WORDS) begin
            eff_words = TW_BITS'(TILE_WORDS);
        end else begin
            eff_words = TW_BITS'(r_tile_words);
        end
    end

    assign accept = push && !full;
    assign key    = {i_batch_index, i_head_index, i_tile_index};

    ltc_front #(
        .ENTRIES   (ENTRIES),
        .SLOT_BITS (SLOT_BITS),
        .CAP_BITS  (CAP_BITS),
        .TW_BITS   (TW_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_key        (key),
        .i_word_index (i_word_index),
        .i_eff_cap    (eff_cap),
        .i_eff_words  (eff_words),
        .o_cmd_push   (cmd_push),
        .o_cmd_flags  (cmd_flags),
        .o_cmd_slot   (cmd_slot)
    );

    assign cmd_in = {cmd_flags, cmd_slot, i_word_index, i_data_word};

    ltc_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (ltc_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_full  (full),
        .o_empty (cmd_empty),
        .o_count ()
    );

    assign {q_flags, q_slot, q_widx, q_data} = cmd_out;

    ltc_back #(
        .ENTRIES    (ENTRIES),
        .TILE_WORDS (TILE_WORDS),
        .WORD_BITS  (WORD_BITS),
        .SLOT_BITS  (SLOT_BITS),
        .TW_BITS    (TW_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd_flags (q_flags),
        .i_cmd_slot  (q_slot),
        .i_cmd_widx  (q_widx),
        .i_cmd_data  (q_data),
        .o_cmd_pop   (cmd_pop),
        .i_eff_words (eff_words),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_hit       (o_hit),
        .o_slot      (o_slot),
        .o_read_word (o_read_word),
        .o_last      (o_last),
        .o_evicted   (o_evicted)
    );

`ifndef SYNTHESIS
    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit) |-> o_last)
        else $error("miss result without last");

    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_evicted) |-> (!o_hit && o_last))
        else $error("eviction flag on a hit or non-final result");

    a_word_only_on_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_read_word != '0)) |-> (o_hit && !o_evicted))
        else $error("read data on a result that carries no tile word");
`endif

endmodule

`default_nettype wire
